@@ sv/rmq_pkg.sv @@
`timescale 1ns / 1ps

package rmq_pkg;

   localparam int DIV_STAGES  = 32;
   localparam int SQRT_STAGES = 16;
   localparam int PIPE_DEPTH  = DIV_STAGES + SQRT_STAGES;

   // Branch codes: which component carries the square root.
   localparam logic [1:0] BR_W = 2'd0;
   localparam logic [1:0] BR_X = 2'd1;
   localparam logic [1:0] BR_Y = 2'd2;
   localparam logic [1:0] BR_Z = 2'd3;

   localparam logic signed [18:0] ONE_Q14 = 19'sd16384;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
   } rmq_matrix_type;

   // Per-item side information that rides alongside the arithmetic.
   typedef struct packed {
      logic [1:0]  branch;
      logic        err;
      logic [2:0]  neg;
      logic [2:0]  ovf;
      logic [16:0] rad;
   } rmq_meta_type;

   // Operands of one long division: partial remainder and dividend bits.
   typedef struct packed {
      logic [16:0] rem;
      logic [31:0] word;
   } rmq_div_op_type;

endpackage

@@ sv/rmq_front.sv @@
`timescale 1ns / 1ps

// Branch selection, radicand and numerator squares, in three stages.
module rmq_front
   import rmq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  rmq_matrix_type in_mat,
   output logic           out_valid,
   output rmq_meta_type   out_meta,
   output rmq_div_op_type out_op [3]
);

   // Stage 1: branch, radicand and differences.
   logic               s1_valid_ff;
   rmq_meta_type       s1_meta_ff, s1_meta_in;
   logic signed [16:0] s1_d_ff [3];
   logic signed [16:0] s1_d_in [3];

   logic signed [16:0] sum_bc, sum_ab, sum_ac;
   logic signed [16:0] a_x, b_x, c_x;
   logic signed [18:0] rad_x;
   logic               hit;

   always_comb begin
      a_x    = 17'(in_mat.m00);
      b_x    = 17'(in_mat.m11);
      c_x    = 17'(in_mat.m22);
      sum_bc = b_x + c_x;
      sum_ab = a_x + b_x;
      sum_ac = a_x + c_x;
      hit    = 1'b1;
      s1_meta_in = '0;
      rad_x  = '0;
      s1_d_in[0] = '0;
      s1_d_in[1] = '0;
      s1_d_in[2] = '0;
      if (sum_bc >= 0 && sum_ab >= 0 && sum_ac >= 0) begin
         s1_meta_in.branch = BR_W;
         rad_x = ONE_Q14 + 19'(a_x) + 19'(b_x) + 19'(c_x);
         s1_d_in[0] = 17'(in_mat.m21) - 17'(in_mat.m12);
         s1_d_in[1] = 17'(in_mat.m02) - 17'(in_mat.m20);
         s1_d_in[2] = 17'(in_mat.m10) - 17'(in_mat.m01);
      end else if (sum_bc <= 0 && a_x >= b_x && a_x >= c_x) begin
         s1_meta_in.branch = BR_X;
         rad_x = ONE_Q14 + 19'(a_x) - 19'(b_x) - 19'(c_x);
         s1_d_in[0] = 17'(in_mat.m21) - 17'(in_mat.m12);
         s1_d_in[1] = 17'(in_mat.m10) + 17'(in_mat.m01);
         s1_d_in[2] = 17'(in_mat.m20) + 17'(in_mat.m02);
      end else if (b_x >= c_x && a_x <= b_x && sum_ac <= 0) begin
         s1_meta_in.branch = BR_Y;
         rad_x = ONE_Q14 - 19'(a_x) + 19'(b_x) - 19'(c_x);
         s1_d_in[0] = 17'(in_mat.m02) - 17'(in_mat.m20);
         s1_d_in[1] = 17'(in_mat.m10) + 17'(in_mat.m01);
         s1_d_in[2] = 17'(in_mat.m21) + 17'(in_mat.m12);
      end else if (b_x <= c_x && sum_ab <= 0 && a_x <= c_x) begin
         s1_meta_in.branch = BR_Z;
         rad_x = ONE_Q14 - 19'(a_x) - 19'(b_x) + 19'(c_x);
         s1_d_in[0] = 17'(in_mat.m10) - 17'(in_mat.m01);
         s1_d_in[1] = 17'(in_mat.m20) + 17'(in_mat.m02);
         s1_d_in[2] = 17'(in_mat.m21) + 17'(in_mat.m12);
      end else begin
         hit = 1'b0;
      end
      s1_meta_in.err = !hit || rad_x <= 0;
      s1_meta_in.rad = s1_meta_in.err ? 17'd1 : rad_x[16:0];
   end

   // Stage 2: magnitudes squared.
   logic         s2_valid_ff;
   rmq_meta_type s2_meta_ff, s2_meta_in;
   logic [33:0]  s2_sq_ff [3];
   logic [33:0]  s2_sq_in [3];
   logic [16:0]  mag [3];

   always_comb begin
      s2_meta_in = s1_meta_ff;
      for (int j = 0; j < 3; j++) begin
         s2_meta_in.neg[j] = s1_d_ff[j][16];
         mag[j] = s1_d_ff[j][16] ? 17'(-s1_d_ff[j]) : 17'(s1_d_ff[j]);
         s2_sq_in[j] = 34'(mag[j]) * 34'(mag[j]);
      end
   end

   // Stage 3: scale by 2^14, split off the top word, flag overflow.
   logic           s3_valid_ff;
   rmq_meta_type   s3_meta_ff, s3_meta_in;
   rmq_div_op_type s3_op_ff [3];
   rmq_div_op_type s3_op_in [3];

   always_comb begin
      s3_meta_in = s2_meta_ff;
      for (int j = 0; j < 3; j++) begin
         s3_op_in[j].rem  = {1'b0, s2_sq_ff[j][33:18]};
         s3_op_in[j].word = {s2_sq_ff[j][17:0], 14'd0};
         s3_meta_in.ovf[j] = {1'b0, s2_sq_ff[j][33:18]} >= s2_meta_ff.rad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_meta_ff <= s1_meta_in;
         s2_meta_ff <= s2_meta_in;
         s3_meta_ff <= s3_meta_in;
         for (int j = 0; j < 3; j++) begin
            s1_d_ff[j]  <= s1_d_in[j];
            s2_sq_ff[j] <= s2_sq_in[j];
            s3_op_ff[j] <= s3_op_in[j];
         end
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_meta  = s3_meta_ff;
   assign out_op    = s3_op_ff;

endmodule

@@ sv/rmq_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage. The partial remainder
// must start below the divisor for the quotient to be meaningful.
module rmq_div
   import rmq_pkg::*;
(
   input  logic           clock,
   input  logic           en,
   input  rmq_div_op_type in_op,
   input  logic [16:0]    in_den,
   output logic [31:0]    quot
);

   rmq_div_op_type op_ff [DIV_STAGES];
   logic [16:0]    den_ff [DIV_STAGES];

   genvar s;
   generate
      for (s = 0; s < DIV_STAGES; s++) begin : g_stage
         rmq_div_op_type src, op_in;
         logic [16:0]    den_src;
         logic [17:0]    trial;
         logic           ge;

         if (s == 0) begin : g_first
            assign src     = in_op;
            assign den_src = in_den;
         end else begin : g_next
            assign src     = op_ff[s-1];
            assign den_src = den_ff[s-1];
         end

         always_comb begin
            trial      = {src.rem, src.word[31]};
            ge         = trial >= {1'b0, den_src};
            op_in.rem  = ge ? 17'(trial - {1'b0, den_src}) : trial[16:0];
            op_in.word = {src.word[30:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               op_ff[s]  <= op_in;
               den_ff[s] <= den_src;
            end
         end
      end
   endgenerate

   assign quot = op_ff[DIV_STAGES-1].word;

endmodule

@@ sv/rmq_isqrt.sv @@
`timescale 1ns / 1ps

// Integer square root, floor, two radicand bits per stage.
module rmq_isqrt
   import rmq_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] radicand,
   output logic [15:0] root
);

   logic [31:0] word_ff [SQRT_STAGES];
   logic [17:0] rem_ff  [SQRT_STAGES];
   logic [15:0] root_ff [SQRT_STAGES];

   genvar s;
   generate
      for (s = 0; s < SQRT_STAGES; s++) begin : g_stage
         logic [31:0] w_src;
         logic [17:0] r_src;
         logic [15:0] q_src;
         logic [19:0] acc, trial;
         logic        ge;

         if (s == 0) begin : g_first
            assign w_src = radicand;
            assign r_src = '0;
            assign q_src = '0;
         end else begin : g_next
            assign w_src = word_ff[s-1];
            assign r_src = rem_ff[s-1];
            assign q_src = root_ff[s-1];
         end

         always_comb begin
            acc   = {r_src, w_src[31:30]};
            trial = {2'b00, q_src, 2'b01};
            ge    = acc >= trial;
         end

         always_ff @(posedge clock) begin
            if (en) begin
               word_ff[s] <= {w_src[29:0], 2'b00};
               rem_ff[s]  <= ge ? 18'(acc - trial) : acc[17:0];
               root_ff[s] <= {q_src[14:0], ge};
            end
         end
      end
   endgenerate

   assign root = root_ff[SQRT_STAGES-1];

endmodule

@@ sv/rotation_matrix_to_quaternion.sv @@
`timescale 1ns / 1ps

// Channel  Direction  tdata                      tuser
// req      in         m00..m22, 16 b each        -
// rsp      out        quat_w, quat_x, quat_y,    branch_taken, convert_error
//                     quat_z, 16 b each
//
// One item enters per cycle while req_tready is high; after its item is
// accepted, each result passes through three front stages, 32 divider
// stages, 16 root stages and the output register.
// Reset (synchronous, active high) empties the pipeline and output buffer.
// A stall on rsp fills a two-entry output buffer; req_tready drops only
// when both entries hold items, and the whole pipeline then freezes.
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // m00 [15:0], m01, m02, m10, m11, m12, m20, m21, m22 [143:128]
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
   output logic [63:0]  rsp_tdata,
   // branch_taken [1:0], convert_error [2]
   output logic [2:0]   rsp_tuser
);

   // The pipeline moves only while the output buffer has a free slot.
   logic en;
   logic skid_valid_ff, skid_valid_in;
   logic out_valid_ff, out_valid_in;
   logic [66:0] out_ff, out_in, skid_ff, skid_in;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   rmq_matrix_type mat;
   assign mat.m00 = req_tdata[15:0];
   assign mat.m01 = req_tdata[31:16];
   assign mat.m02 = req_tdata[47:32];
   assign mat.m10 = req_tdata[63:48];
   assign mat.m11 = req_tdata[79:64];
   assign mat.m12 = req_tdata[95:80];
   assign mat.m20 = req_tdata[111:96];
   assign mat.m21 = req_tdata[127:112];
   assign mat.m22 = req_tdata[143:128];

   logic           f_valid;
   rmq_meta_type   f_meta;
   rmq_div_op_type f_op [3];

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_mat    (mat),
      .out_valid (f_valid),
      .out_meta  (f_meta),
      .out_op    (f_op)
   );

   // Side information and valid bits follow the arithmetic stage by stage.
   logic         vld_ff  [PIPE_DEPTH];
   rmq_meta_type meta_ff [PIPE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= f_valid;
         for (int i = 1; i < PIPE_DEPTH; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= f_meta;
         for (int i = 1; i < PIPE_DEPTH; i++) meta_ff[i] <= meta_ff[i-1];
      end
   end

   logic [31:0] quot [3];
   logic [31:0] sq_in [4];
   logic [15:0] sq_out [4];
   rmq_meta_type dm;

   assign dm = meta_ff[DIV_STAGES-1];

   genvar j;
   generate
      for (j = 0; j < 3; j++) begin : g_div
         rmq_div u_div (
            .clock  (clock),
            .en     (en),
            .in_op  (f_op[j]),
            .in_den (f_meta.rad),
            .quot   (quot[j])
         );
         // A quotient of 2^32 or more saturates the component anyway.
         assign sq_in[j] = dm.ovf[j] ? '1 : quot[j];
      end
   endgenerate

   assign sq_in[3] = {1'b0, dm.rad, 14'd0};

   generate
      for (j = 0; j < 4; j++) begin : g_sqrt
         rmq_isqrt u_isqrt (
            .clock    (clock),
            .en       (en),
            .radicand (sq_in[j]),
            .root     (sq_out[j])
         );
      end
   endgenerate

   // Halve with rounding, apply sign, saturate positive values, place by branch; errors give zero.
   rmq_meta_type em;
   logic [16:0]  k [4];
   logic [15:0]  c [4];
   logic [15:0]  qw, qx, qy, qz;

   assign em = meta_ff[PIPE_DEPTH-1];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         k[i] = ({1'b0, sq_out[i]} + 17'd1) >> 1;
         if (i < 3 && em.neg[i]) begin
            c[i] = 16'(17'd0 - k[i]);
         end else begin
            c[i] = k[i][15] ? 16'h7FFF : k[i][15:0];
         end
      end
      case (em.branch)
         BR_W: begin qw = c[3]; qx = c[0]; qy = c[1]; qz = c[2]; end
         BR_X: begin qw = c[0]; qx = c[3]; qy = c[1]; qz = c[2]; end
         BR_Y: begin qw = c[0]; qx = c[1]; qy = c[3]; qz = c[2]; end
         BR_Z: begin qw = c[0]; qx = c[1]; qy = c[2]; qz = c[3]; end
         default: begin qw = '0; qx = '0; qy = '0; qz = '0; end
      endcase
      if (em.err) begin
         qw = '0; qx = '0; qy = '0; qz = '0;
      end
   end

   logic push, pop;
   logic [66:0] res;

   assign res  = {em.err, em.branch, qz, qy, qx, qw};
   assign push = en && vld_ff[PIPE_DEPTH-1];
   assign pop  = out_valid_ff && rsp_tready;

   // Two-entry output buffer: out_ff is the head, skid_ff the second slot.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff[63:0];
   assign rsp_tuser  = out_ff[66:64];

`ifndef SYNTH
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("second output slot holds an item while the head is empty");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      push && em.err |-> res[63:0] == 64'd0)
      else $error("error result carries a nonzero quaternion");

   a_root_nonneg: assert property (@(posedge clock) disable iff (reset)
      push && !em.err |-> !c[3][15])
      else $error("root component came out negative");

   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !en && vld_ff[PIPE_DEPTH-1] |=> vld_ff[PIPE_DEPTH-1])
      else $error("item at the pipeline exit lost during a stall");
`endif

endmodule
